### hw/rtl/rfd_pkg.sv
// Shared types and constants for the RPC frame deframer.
// Holds the phase encoding, result codes, register indexes and channel widths.
// No dependencies.
package rfd_pkg;

   localparam int DATA_W    = 8;
   localparam int LEN_W     = 31;
   localparam int WORD_W    = 32;
   localparam int KIND_W    = 3;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 31;

   // Trailer is the 4 checksum bytes plus the end marker byte.
   localparam logic [2:0]       TAIL_BYTES    = 3'd5;
   localparam logic [2:0]       WORD_BYTES    = 3'd4;
   localparam logic [WORD_W-1:0] MIN_FRAME_LEN = 32'd26;

   localparam logic [DATA_W-1:0] START_MARKER_RST = 8'd2;
   localparam logic [DATA_W-1:0] END_MARKER_RST   = 8'd3;
   localparam logic [LEN_W-1:0]  MAX_LEN_RST      = 31'h7FFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN      = 2'd2;

   localparam logic [KIND_W-1:0] KIND_REQ_ID  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_METHOD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ERRTEXT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_END  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERRUN  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd4;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_LEN,
      PH_IDLEN,
      PH_ID,
      PH_MLEN,
      PH_METH,
      PH_ECODE,
      PH_ELEN,
      PH_EINFO,
      PH_PAYLOAD,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [LEN_W-1:0]       remaining;
      logic                   overrun;
   } slot_type;

   typedef struct packed {
      logic [KIND_W-1:0]        field_kind;
      logic [DATA_W-1:0]        field_byte;
      logic [STATUS_W-1:0]      frame_status;
      logic signed [WORD_W-1:0] error_code;
      logic [LEN_W-1:0]         frame_length;
      logic                     frame_done;
   } result_type;

endpackage

### hw/rtl/rfd_if.sv
// Channel interfaces of the RPC frame deframer: byte input, result output
// and register write port. Depends on rfd_pkg for the field widths.
interface rfd_req_if import rfd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface rfd_rsp_if import rfd_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        field_kind;
   logic [DATA_W-1:0]        field_byte;
   logic [STATUS_W-1:0]      frame_status;
   logic signed [WORD_W-1:0] error_code;
   logic [LEN_W-1:0]         frame_length;
   logic                     frame_done;

   modport source (output valid, output field_kind, output field_byte,
                   output frame_status, output error_code, output frame_length,
                   output frame_done, input ready);
   modport sink   (input valid, input field_kind, input field_byte,
                   input frame_status, input error_code, input frame_length,
                   input frame_done, output ready);
endinterface

interface rfd_csr_if import rfd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/rpc_frame_deframer_core.sv
// Top level of the RPC frame deframer: one byte in, tagged field bytes and
// frame status out. Depends on rfd_pkg and the channel interfaces in rfd_if.
//
// Usage
// The req channel carries one received byte per transfer. The block skips
// bytes until the start marker, then parses the length word, the request id,
// method name, error code and error text fields, the payload, the checksum
// and the end marker. Each request id, method name, error text or payload
// byte leaves as one rsp transfer tagged with its kind; the last byte of a
// frame gives one status transfer with frame_done set. A length word outside
// 26 to max_frame_len gives a bad length status at once and hunting resumes.
// The csr channel writes start_marker (index 0), end_marker (index 1) and
// max_frame_len (index 2); it is always ready and must be written only while
// idle, which the block does not enforce. A byte is registered on its
// transfer and processed once the result register can take its result;
// while the rsp receiver keeps up, one byte is taken every clock.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and returns the parser to hunting.
// When the rsp receiver stalls, the input register takes one more byte and
// req ready then drops until the result is taken.
module rpc_frame_deframer_core
   import rfd_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   rfd_req_if.sink   req_ch,
   rfd_rsp_if.source rsp_ch,
   rfd_csr_if.sink   csr_ch
);

   // Configuration registers.
   logic [DATA_W-1:0] start_marker_ff;
   logic [DATA_W-1:0] end_marker_ff;
   logic [LEN_W-1:0]  max_len_ff;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_byte_ff;

   // Parser state.
   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [WORD_W-1:0] xor_ff, xor_in;
   logic [WORD_W-1:0] rck_ff, rck_in;
   logic [WORD_W-1:0] ec_ff, ec_in;
   logic              ovr_ff, ovr_in;

   // Result register.
   logic              out_valid_ff;
   result_type        out_ff;
   logic              emit;
   result_type        result;

   logic              advance;

   // Shared decode of the byte being processed.
   logic [DATA_W-1:0] b;
   logic [WORD_W-1:0] b_lane;
   logic [WORD_W-1:0] word_next;
   logic [LEN_W-1:0]  ck_pos;
   logic [LEN_W-1:0]  last_pos;
   logic              in_ck;
   logic [1:0]        ck_lane;
   logic [WORD_W-1:0] xor_next;
   logic [WORD_W-1:0] rck_next;
   logic              is_last;
   logic [WORD_W-1:0] ri;
   logic [LEN_W-1:0]  rem_dec;
   logic              bad_len;
   logic              len_done;

   // A slot whose bytes cannot fit the claimed frame: swallow the rest.
   function automatic slot_type overrun_slot();
      slot_type s;
      s.phase     = PH_TAIL;
      s.remaining = '0;
      s.overrun   = 1'b1;
      return s;
   endfunction

   function automatic slot_type word_slot(phase_type ph, logic [WORD_W-1:0] r,
                                          logic [LEN_W-1:0] l);
      slot_type s;
      if (({2'b00, r} + {31'd0, WORD_BYTES}) >= {3'b000, l}) begin
         s = overrun_slot();
      end else begin
         s.phase     = ph;
         s.remaining = {{(LEN_W-3){1'b0}}, WORD_BYTES};
         s.overrun   = 1'b0;
      end
      return s;
   endfunction

   function automatic slot_type payload_slot(logic [WORD_W-1:0] r,
                                             logic [LEN_W-1:0] l);
      slot_type          s;
      logic [WORD_W+1:0] left;
      left = {3'b000, l} - {31'd0, TAIL_BYTES} - {2'b00, r};
      s.overrun = 1'b0;
      if (({2'b00, r} + {31'd0, TAIL_BYTES}) >= {3'b000, l}) begin
         s.phase     = PH_TAIL;
         s.remaining = '0;
      end else begin
         s.phase     = PH_PAYLOAD;
         s.remaining = left[LEN_W-1:0];
      end
      return s;
   endfunction

   // A data field of n bytes at position r; an empty field moves straight on.
   function automatic slot_type data_slot(phase_type ph, logic [WORD_W-1:0] r,
                                          logic [WORD_W-1:0] n,
                                          logic [LEN_W-1:0] l);
      slot_type          s;
      logic [WORD_W+1:0] ends;
      ends = {2'b00, r} + {2'b00, n};
      if (ends >= {3'b000, l} ||
          (ph == PH_EINFO && (ends + {31'd0, TAIL_BYTES}) > {3'b000, l})) begin
         s = overrun_slot();
      end else if (n == '0) begin
         case (ph)
            PH_ID:   s = word_slot(PH_MLEN, r, l);
            PH_METH: s = word_slot(PH_ECODE, r, l);
            default: s = payload_slot(r, l);
         endcase
      end else begin
         s.phase     = ph;
         s.remaining = n[LEN_W-1:0];
         s.overrun   = 1'b0;
      end
      return s;
   endfunction

   // Handshakes. The input register moves on when the result register is
   // free or being emptied in this cycle.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);

   // Byte decode.
   assign b         = in_byte_ff;
   assign b_lane    = {24'd0, b} << {pos_ff[1:0], 3'b000};
   assign word_next = {word_ff[WORD_W-9:0], b};
   assign ck_pos    = len_ff - {{(LEN_W-3){1'b0}}, TAIL_BYTES};
   assign last_pos  = len_ff - {{(LEN_W-1){1'b0}}, 1'b1};
   assign in_ck     = (pos_ff >= ck_pos) && (pos_ff < last_pos);
   assign ck_lane   = pos_ff[1:0] - ck_pos[1:0];
   assign xor_next  = in_ck ? xor_ff : (xor_ff ^ b_lane);
   assign rck_next  = in_ck ? (rck_ff | ({24'd0, b} << {ck_lane, 3'b000})) : rck_ff;
   assign is_last   = pos_ff >= last_pos;
   assign ri        = {1'b0, pos_ff} + 32'd1;
   assign rem_dec   = rem_ff - {{(LEN_W-1){1'b0}}, 1'b1};
   assign len_done  = pos_ff >= {{(LEN_W-3){1'b0}}, WORD_BYTES};
   assign bad_len   = (word_next < MIN_FRAME_LEN) || (word_next > {1'b0, max_len_ff});

   // Next state of the parser.
   always_comb begin
      slot_type s;
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      word_in  = word_ff;
      rem_in   = rem_ff;
      xor_in   = xor_ff;
      rck_in   = rck_ff;
      ec_in    = ec_ff;
      ovr_in   = ovr_ff;
      s        = overrun_slot();
      case (phase_ff)
         PH_LEN: begin
            word_in = word_next;
            xor_in  = xor_ff ^ b_lane;
            pos_in  = pos_ff + {{(LEN_W-1){1'b0}}, 1'b1};
            if (len_done) begin
               len_in = word_next[LEN_W-1:0];
               if (bad_len) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end else begin
                  // The first length prefix always fits a frame of legal size.
                  phase_in = PH_IDLEN;
                  rem_in   = {{(LEN_W-3){1'b0}}, WORD_BYTES};
                  word_in  = '0;
               end
            end
         end
         PH_IDLEN, PH_ID, PH_MLEN, PH_METH, PH_ECODE, PH_ELEN, PH_EINFO,
         PH_PAYLOAD, PH_TAIL: begin
            xor_in = xor_next;
            rck_in = rck_next;
            if (is_last) begin
               phase_in = PH_HUNT;
               pos_in   = '0;
               rem_in   = '0;
            end else begin
               pos_in = pos_ff + {{(LEN_W-1){1'b0}}, 1'b1};
               if (phase_ff != PH_TAIL && rem_ff != '0) begin
                  rem_in = rem_dec;
                  if (phase_ff inside {PH_IDLEN, PH_MLEN, PH_ECODE, PH_ELEN}) begin
                     word_in = word_next;
                  end
                  if (rem_dec == '0) begin
                     case (phase_ff)
                        PH_ID:     s = word_slot(PH_MLEN, ri, len_ff);
                        PH_METH:   s = word_slot(PH_ECODE, ri, len_ff);
                        PH_EINFO:  s = payload_slot(ri, len_ff);
                        PH_IDLEN:  s = data_slot(PH_ID, ri, word_next, len_ff);
                        PH_MLEN:   s = data_slot(PH_METH, ri, word_next, len_ff);
                        PH_ECODE:  s = word_slot(PH_ELEN, ri, len_ff);
                        PH_ELEN:   s = data_slot(PH_EINFO, ri, word_next, len_ff);
                        default: begin
                           s.phase     = PH_TAIL;
                           s.remaining = '0;
                           s.overrun   = 1'b0;
                        end
                     endcase
                     if (phase_ff == PH_ECODE) begin
                        ec_in = word_next;
                     end
                     phase_in = s.phase;
                     rem_in   = s.remaining;
                     ovr_in   = ovr_ff | s.overrun;
                     // Every word slot starts collecting from zero.
                     word_in  = '0;
                  end
               end
            end
         end
         default: begin
            // Hunting for the start marker.
            if (b == start_marker_ff) begin
               phase_in = PH_LEN;
               pos_in   = {{(LEN_W-1){1'b0}}, 1'b1};
               word_in  = '0;
               rem_in   = {{(LEN_W-3){1'b0}}, WORD_BYTES};
               xor_in   = {24'd0, b};
               rck_in   = '0;
               ec_in    = '0;
               ovr_in   = 1'b0;
            end
         end
      endcase
   end

   // Result of the byte being processed.
   always_comb begin
      emit   = 1'b0;
      result = '0;
      case (phase_ff)
         PH_LEN: begin
            if (len_done && bad_len) begin
               emit                = 1'b1;
               result.field_kind   = KIND_STATUS;
               result.frame_status = ST_BAD_LEN;
               result.frame_length = word_next[LEN_W-1:0];
               result.frame_done   = 1'b1;
            end
         end
         PH_IDLEN, PH_ID, PH_MLEN, PH_METH, PH_ECODE, PH_ELEN, PH_EINFO,
         PH_PAYLOAD, PH_TAIL: begin
            if (is_last) begin
               emit                = 1'b1;
               result.field_kind   = KIND_STATUS;
               result.error_code   = ec_ff;
               result.frame_length = len_ff;
               result.frame_done   = 1'b1;
               // Ranking: end marker, then overrun, then checksum.
               if (b != end_marker_ff) begin
                  result.frame_status = ST_BAD_END;
               end else if (ovr_ff) begin
                  result.frame_status = ST_OVERRUN;
               end else if (xor_next != rck_next) begin
                  result.frame_status = ST_CHECKSUM;
               end else begin
                  result.frame_status = ST_OK;
               end
            end else if (rem_ff != '0 &&
                         phase_ff inside {PH_ID, PH_METH, PH_EINFO, PH_PAYLOAD}) begin
               emit              = 1'b1;
               result.field_byte = b;
               case (phase_ff)
                  PH_ID:    result.field_kind = KIND_REQ_ID;
                  PH_METH:  result.field_kind = KIND_METHOD;
                  PH_EINFO: result.field_kind = KIND_ERRTEXT;
                  default:  result.field_kind = KIND_PAYLOAD;
               endcase
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
         max_len_ff      <= MAX_LEN_RST;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         phase_ff        <= PH_HUNT;
         pos_ff          <= '0;
         ovr_ff          <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_START_MARKER: start_marker_ff <= csr_ch.data[DATA_W-1:0];
               CSR_END_MARKER:   end_marker_ff   <= csr_ch.data[DATA_W-1:0];
               CSR_MAX_LEN:      max_len_ff      <= csr_ch.data[LEN_W-1:0];
               default: begin
               end
            endcase
         end
         in_valid_ff <= in_valid_in;
         if (advance) begin
            out_valid_ff <= emit;
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            ovr_ff       <= ovr_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
      end
      if (advance) begin
         len_ff  <= len_in;
         word_ff <= word_in;
         rem_ff  <= rem_in;
         xor_ff  <= xor_in;
         rck_ff  <= rck_in;
         ec_ff   <= ec_in;
         if (emit) begin
            out_ff <= result;
         end
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.field_kind   = out_ff.field_kind;
   assign rsp_ch.field_byte   = out_ff.field_byte;
   assign rsp_ch.frame_status = out_ff.frame_status;
   assign rsp_ch.error_code   = out_ff.error_code;
   assign rsp_ch.frame_length = out_ff.frame_length;
   assign rsp_ch.frame_done   = out_ff.frame_done;

endmodule
